// ----- hdl/oaht_pkg.sv -----
// shared types, constants and helper functions of the hash table
`timescale 1ns / 1ps

package oaht_pkg;

  // storage geometry
  localparam int unsigned SLOTS      = 64;
  localparam int unsigned VALUE_BITS = 64;
  localparam int unsigned SLOT_W     = $clog2(SLOTS);
  localparam int unsigned CAP_W      = SLOT_W + 1;

  // fixed field widths
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned TAG_W      = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned IN_DATA_W  = 136;
  localparam int unsigned OUT_DATA_W = 136;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0]  CFG_CAPACITY  = 8'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_KEY_BYTES = 8'd1;
  localparam logic [CFG_DATA_W-1:0] CAP_RESET     = 7'd64;
  localparam logic [3:0]            KB_RESET      = 4'd8;

  // operation codes
  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_DUPLICATE = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  // tag codes and hash seed
  localparam logic [TAG_W-1:0] TAG_VACANT  = 32'd0;
  localparam logic [TAG_W-1:0] TAG_DELETED = 32'd1;
  localparam logic [TAG_W-1:0] TAG_MIN     = 32'd2;
  localparam logic [TAG_W-1:0] HASH_SEED   = 32'd5381;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_CHECK,
    ST_DONE
  } state_e;

  // effective configuration seen by the sequencer
  typedef struct packed {
    logic [CAP_W-1:0]  cap;
    logic [CAP_W-1:0]  span;
    logic [SLOT_W-1:0] mask;
    logic [3:0]        kb;
    logic [KEY_W-1:0]  key_mask;
  } cfg_t;

  // shared adder operands
  typedef struct packed {
    logic [TAG_W-1:0] a;
    logic [TAG_W-1:0] b;
    logic [7:0]       c;
  } alu_req_t;

  // store read request and response
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic [TAG_W-1:0]      tag;
    logic [KEY_W-1:0]      key;
    logic [VALUE_BITS-1:0] value;
  } rd_rsp_t;

  // store write request, kv set also writes key and value
  typedef struct packed {
    logic                  en;
    logic                  kv;
    logic [SLOT_W-1:0]     addr;
    logic [TAG_W-1:0]      tag;
    logic [KEY_W-1:0]      key;
    logic [VALUE_BITS-1:0] value;
  } wr_req_t;

  // capacity clamped to 1..SLOTS
  function automatic logic [CAP_W-1:0] eff_capacity(input logic [CFG_DATA_W-1:0] c);
    logic [CAP_W-1:0] r;
    if (c == '0) begin
      r = CAP_W'(1);
    end else if (32'(c) > SLOTS) begin
      r = CAP_W'(SLOTS);
    end else begin
      r = CAP_W'(c);
    end
    return r;
  endfunction

  // key length clamped to 1..8 bytes
  function automatic logic [3:0] eff_key_bytes(input logic [3:0] k);
    logic [3:0] r;
    if (k == 4'd0) begin
      r = 4'd1;
    end else if (k > 4'd8) begin
      r = 4'd8;
    end else begin
      r = k;
    end
    return r;
  endfunction

  // low kb bytes set
  function automatic logic [KEY_W-1:0] key_mask_of(input logic [3:0] kb);
    logic [KEY_W-1:0] m;
    for (int b = 0; b < 8; b++) begin
      m[8*b +: 8] = (4'(b) < kb) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  // probe span minus one: cap-1 with all lower bits filled
  function automatic logic [SLOT_W-1:0] span_mask_of(input logic [CAP_W-1:0] cap);
    logic [SLOT_W-1:0] v;
    logic [SLOT_W-1:0] m;
    v = SLOT_W'(cap - CAP_W'(1));
    for (int b = 0; b < SLOT_W; b++) begin
      m[b] = |(v >> b);
    end
    return m;
  endfunction

endpackage

// ----- hdl/open_addressing_hash_table.sv -----
// top level of the open-addressing hash table with triangular probing
//
//   channel  direction  transfer when              payload
//   s_axis   in         s_axis_tvalid & tready     mode, key, value
//   m_axis   out        m_axis_tvalid & tready     status, value_out, key_out, slot_index
//   cfg      in         cfg_valid & cfg_ready      register index, write data
//
// an item is accepted in idle, then hashed over key_bytes bytes through the shared adder;
// each probe is a registered store read followed by a compare, a slot past the
// capacity is stepped over without a read, and the done state loads the output register.
// lookups and removes skip probing while no insert has been counted, and a walk
// makes at most span probes.
// reset clears the tag written bits at once, no clearing pass is needed.
// a result waiting in the output register stalls only the finish of the next item.
`timescale 1ns / 1ps

module open_addressing_hash_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input items
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // mode [1:0], key [65:2], value [129:66], zero [135:130]
  input  logic [oaht_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // result items
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // status [1:0], value_out [65:2], key_out [129:66], slot_index [135:130]
  output logic [oaht_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [oaht_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [oaht_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  logic [oaht_pkg::CFG_DATA_W-1:0]  cap_cfg_q;
  logic [3:0]                       kb_cfg_q;
  oaht_pkg::cfg_t                   cfg;
  oaht_pkg::alu_req_t               alu_req;
  logic [oaht_pkg::TAG_W-1:0]       alu_sum;
  oaht_pkg::rd_req_t                rd_req;
  oaht_pkg::rd_rsp_t                rd_rsp;
  oaht_pkg::wr_req_t                wr_req;
  logic [1:0]                       out_status;
  logic [oaht_pkg::VALUE_BITS-1:0]  out_value;
  logic [oaht_pkg::KEY_W-1:0]       out_key;
  logic [oaht_pkg::SLOT_W-1:0]      out_slot;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_cfg_q <= oaht_pkg::CAP_RESET;
      kb_cfg_q  <= oaht_pkg::KB_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        oaht_pkg::CFG_CAPACITY:  cap_cfg_q <= cfg_data_i;
        oaht_pkg::CFG_KEY_BYTES: kb_cfg_q  <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  // effective configuration
  always_comb begin
    cfg.cap      = oaht_pkg::eff_capacity(cap_cfg_q);
    cfg.mask     = oaht_pkg::span_mask_of(cfg.cap);
    cfg.span     = oaht_pkg::CAP_W'(cfg.mask) + oaht_pkg::CAP_W'(1);
    cfg.kb       = oaht_pkg::eff_key_bytes(kb_cfg_q);
    cfg.key_mask = oaht_pkg::key_mask_of(cfg.kb);
  end

  oaht_alu u_alu (
    .req_i (alu_req),
    .sum_o (alu_sum)
  );

  oaht_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_req_i (rd_req),
    .rd_rsp_o (rd_rsp),
    .wr_req_i (wr_req)
  );

  oaht_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_mode_i    (s_axis_tdata_i[1:0]),
    .in_key_i     (s_axis_tdata_i[65:2]),
    .in_value_i   (s_axis_tdata_i[66 +: oaht_pkg::VALUE_BITS]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (out_status),
    .out_value_o  (out_value),
    .out_key_o    (out_key),
    .out_slot_o   (out_slot),
    .alu_req_o    (alu_req),
    .alu_sum_i    (alu_sum),
    .rd_req_o     (rd_req),
    .rd_rsp_i     (rd_rsp),
    .wr_req_o     (wr_req)
  );

  // result packing
  always_comb begin
    m_axis_tdata_o[1:0]     = out_status;
    m_axis_tdata_o[65:2]    = 64'(out_value);
    m_axis_tdata_o[129:66]  = out_key;
    m_axis_tdata_o[135:130] = 6'(out_slot);
  end

endmodule

// ----- hdl/oaht_alu.sv -----
// shared three-input adder used for hashing and probe stepping
`timescale 1ns / 1ps

module oaht_alu (
  input  oaht_pkg::alu_req_t               req_i,
  output logic [oaht_pkg::TAG_W-1:0]       sum_o
);

  // a + b + zero-extended c, wraps at 32 bits
  assign sum_o = req_i.a + req_i.b + oaht_pkg::TAG_W'(req_i.c);

endmodule

// ----- hdl/oaht_store.sv -----
// slot store: tag, key and value memories with per-slot written bits
`timescale 1ns / 1ps

module oaht_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  oaht_pkg::rd_req_t rd_req_i,
  output oaht_pkg::rd_rsp_t rd_rsp_o,
  input  oaht_pkg::wr_req_t wr_req_i
);

  logic [oaht_pkg::TAG_W-1:0]      tag_mem [oaht_pkg::SLOTS];
  logic [oaht_pkg::KEY_W-1:0]      key_mem [oaht_pkg::SLOTS];
  logic [oaht_pkg::VALUE_BITS-1:0] val_mem [oaht_pkg::SLOTS];
  logic [oaht_pkg::SLOTS-1:0]      vld_q;

  logic [oaht_pkg::TAG_W-1:0]      rd_tag_q;
  logic [oaht_pkg::KEY_W-1:0]      rd_key_q;
  logic [oaht_pkg::VALUE_BITS-1:0] rd_val_q;
  logic                            rd_vld_q;

  // written bits, cleared at reset so every slot starts vacant
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_req_i.en) begin
      vld_q[wr_req_i.addr] <= 1'b1;
    end
  end

  // memory writes
  always_ff @(posedge clk_i) begin
    if (wr_req_i.en) begin
      tag_mem[wr_req_i.addr] <= wr_req_i.tag;
      if (wr_req_i.kv) begin
        key_mem[wr_req_i.addr] <= wr_req_i.key;
        val_mem[wr_req_i.addr] <= wr_req_i.value;
      end
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_req_i.en) begin
      rd_tag_q <= tag_mem[rd_req_i.addr];
      rd_key_q <= key_mem[rd_req_i.addr];
      rd_val_q <= val_mem[rd_req_i.addr];
      rd_vld_q <= vld_q[rd_req_i.addr];
    end
  end

  // a never written slot reads as vacant
  always_comb begin
    rd_rsp_o.tag   = rd_vld_q ? rd_tag_q : oaht_pkg::TAG_VACANT;
    rd_rsp_o.key   = rd_key_q;
    rd_rsp_o.value = rd_val_q;
  end

endmodule

// ----- hdl/oaht_ctrl.sv -----
// operation sequencer: hashing, probing, store updates and result register
`timescale 1ns / 1ps

module oaht_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  oaht_pkg::cfg_t                     cfg_i,
  // input item
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         in_mode_i,
  input  logic [oaht_pkg::KEY_W-1:0]         in_key_i,
  input  logic [oaht_pkg::VALUE_BITS-1:0]    in_value_i,
  // result item
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         out_status_o,
  output logic [oaht_pkg::VALUE_BITS-1:0]    out_value_o,
  output logic [oaht_pkg::KEY_W-1:0]         out_key_o,
  output logic [oaht_pkg::SLOT_W-1:0]        out_slot_o,
  // shared adder
  output oaht_pkg::alu_req_t                 alu_req_o,
  input  logic [oaht_pkg::TAG_W-1:0]         alu_sum_i,
  // slot store
  output oaht_pkg::rd_req_t                  rd_req_o,
  input  oaht_pkg::rd_rsp_t                  rd_rsp_i,
  output oaht_pkg::wr_req_t                  wr_req_o
);

  oaht_pkg::state_e state_q, state_d;

  logic [1:0]                      mode_q, mode_d;
  logic [oaht_pkg::KEY_W-1:0]      key_q, key_d;
  logic [oaht_pkg::VALUE_BITS-1:0] val_q, val_d;
  logic [oaht_pkg::TAG_W-1:0]      hash_q, hash_d;
  logic [2:0]                      byte_cnt_q, byte_cnt_d;
  logic [oaht_pkg::CAP_W-1:0]      step_q, step_d;
  logic [oaht_pkg::SLOT_W-1:0]     pos_q, pos_d;
  logic [oaht_pkg::CNT_W-1:0]      add_cnt_q, add_cnt_d;

  logic [1:0]                      res_status_q, res_status_d;
  logic [oaht_pkg::VALUE_BITS-1:0] res_val_q, res_val_d;
  logic [oaht_pkg::KEY_W-1:0]      res_key_q, res_key_d;
  logic [oaht_pkg::SLOT_W-1:0]     res_idx_q, res_idx_d;

  logic                            out_valid_q, out_valid_d;
  logic [1:0]                      out_status_q, out_status_d;
  logic [oaht_pkg::VALUE_BITS-1:0] out_val_q, out_val_d;
  logic [oaht_pkg::KEY_W-1:0]      out_key_q, out_key_d;
  logic [oaht_pkg::SLOT_W-1:0]     out_idx_q, out_idx_d;

  logic                            is_find;
  logic                            is_ins;
  logic                            last_byte;
  logic                            skip_probe;
  logic [oaht_pkg::TAG_W-1:0]      hash_fixed;
  logic                            exhausted;
  logic                            beyond;
  logic                            key_match;
  logic                            check_done;
  logic                            advance;
  logic                            out_free;

  // decode of the current operation
  always_comb begin
    is_find    = (mode_q == oaht_pkg::MODE_LOOKUP) || (mode_q == oaht_pkg::MODE_REMOVE);
    is_ins     = (mode_q == oaht_pkg::MODE_INSERT);
    last_byte  = (byte_cnt_q == 3'(cfg_i.kb - 4'd1));
    skip_probe = !is_ins && !(is_find && (add_cnt_q != '0));
    hash_fixed = (alu_sum_i < oaht_pkg::TAG_MIN) ? oaht_pkg::TAG_MIN : alu_sum_i;
    exhausted  = (step_q == cfg_i.span);
    beyond     = (oaht_pkg::CAP_W'(pos_q) >= cfg_i.cap);
    key_match  = (rd_rsp_i.tag == hash_q) && ((rd_rsp_i.key & cfg_i.key_mask) == key_q);
    if (is_find) begin
      check_done = (rd_rsp_i.tag == oaht_pkg::TAG_VACANT) || key_match;
    end else begin
      check_done = key_match || (rd_rsp_i.tag < oaht_pkg::TAG_MIN);
    end
    advance    = ((state_q == oaht_pkg::ST_PROBE) && !exhausted && beyond) ||
                 ((state_q == oaht_pkg::ST_CHECK) && !check_done);
    out_free   = !out_valid_q || out_ready_i;
  end

  // shared adder operands: djb2 step or triangular probe step
  always_comb begin
    if (state_q == oaht_pkg::ST_HASH) begin
      alu_req_o.a = hash_q << 5;
      alu_req_o.b = hash_q;
      alu_req_o.c = key_q[8*byte_cnt_q +: 8];
    end else begin
      alu_req_o.a = oaht_pkg::TAG_W'(pos_q);
      alu_req_o.b = oaht_pkg::TAG_W'(step_q);
      alu_req_o.c = 8'd1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      oaht_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = oaht_pkg::ST_HASH;
        end
      end
      oaht_pkg::ST_HASH: begin
        if (last_byte) begin
          state_d = skip_probe ? oaht_pkg::ST_DONE : oaht_pkg::ST_PROBE;
        end
      end
      oaht_pkg::ST_PROBE: begin
        if (exhausted) begin
          state_d = oaht_pkg::ST_DONE;
        end else if (!beyond) begin
          state_d = oaht_pkg::ST_CHECK;
        end
      end
      oaht_pkg::ST_CHECK: begin
        state_d = check_done ? oaht_pkg::ST_DONE : oaht_pkg::ST_PROBE;
      end
      oaht_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = oaht_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = oaht_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and store requests
  always_comb begin
    mode_d       = mode_q;
    key_d        = key_q;
    val_d        = val_q;
    hash_d       = hash_q;
    byte_cnt_d   = byte_cnt_q;
    step_d       = step_q;
    pos_d        = pos_q;
    add_cnt_d    = add_cnt_q;
    res_status_d = res_status_q;
    res_val_d    = res_val_q;
    res_key_d    = res_key_q;
    res_idx_d    = res_idx_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_val_d    = out_val_q;
    out_key_d    = out_key_q;
    out_idx_d    = out_idx_q;
    rd_req_o     = '{en: 1'b0, addr: pos_q};
    wr_req_o     = '{en: 1'b0, kv: 1'b0, addr: pos_q, tag: hash_q, key: key_q, value: val_q};

    case (state_q)
      oaht_pkg::ST_IDLE: begin
        // take a new item, count insert attempts
        if (in_valid_i) begin
          mode_d       = in_mode_i;
          key_d        = in_key_i & cfg_i.key_mask;
          val_d        = in_value_i;
          hash_d       = oaht_pkg::HASH_SEED;
          byte_cnt_d   = '0;
          step_d       = '0;
          res_status_d = (in_mode_i == oaht_pkg::MODE_INSERT) ? oaht_pkg::STAT_FULL :
                                                                 oaht_pkg::STAT_NOT_FOUND;
          res_val_d    = '0;
          res_key_d    = '0;
          res_idx_d    = '0;
          if ((in_mode_i == oaht_pkg::MODE_INSERT) && (add_cnt_q != '1)) begin
            add_cnt_d = add_cnt_q + oaht_pkg::CNT_W'(1);
          end
        end
      end
      oaht_pkg::ST_HASH: begin
        // one key byte per cycle
        hash_d     = alu_sum_i;
        byte_cnt_d = byte_cnt_q + 3'd1;
        if (last_byte) begin
          hash_d = hash_fixed;
          pos_d  = hash_fixed[oaht_pkg::SLOT_W-1:0] & cfg_i.mask;
        end
      end
      oaht_pkg::ST_PROBE: begin
        // read the slot unless the span is used up or the slot lies past the capacity
        rd_req_o.en = !exhausted && !beyond;
      end
      oaht_pkg::ST_CHECK: begin
        if (is_find) begin
          if (key_match) begin
            res_status_d = oaht_pkg::STAT_OK;
            res_val_d    = rd_rsp_i.value;
            res_key_d    = rd_rsp_i.key;
            res_idx_d    = pos_q;
            if (mode_q == oaht_pkg::MODE_REMOVE) begin
              wr_req_o.en  = 1'b1;
              wr_req_o.tag = oaht_pkg::TAG_DELETED;
            end
          end
        end else if (key_match) begin
          res_status_d = oaht_pkg::STAT_DUPLICATE;
        end else if (rd_rsp_i.tag < oaht_pkg::TAG_MIN) begin
          res_status_d = oaht_pkg::STAT_OK;
          res_idx_d    = pos_q;
          wr_req_o.en  = 1'b1;
          wr_req_o.kv  = 1'b1;
        end
      end
      oaht_pkg::ST_DONE: begin
        // hand the result to the output register
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_val_d    = res_val_q;
          out_key_d    = res_key_q;
          out_idx_d    = res_idx_q;
        end
      end
      default: begin
      end
    endcase

    // next probe position: pos + step + 1 within the span
    if (advance) begin
      pos_d  = alu_sum_i[oaht_pkg::SLOT_W-1:0] & cfg_i.mask;
      step_d = step_q + oaht_pkg::CAP_W'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= oaht_pkg::ST_IDLE;
      add_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      add_cnt_q   <= add_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    key_q        <= key_d;
    val_q        <= val_d;
    hash_q       <= hash_d;
    byte_cnt_q   <= byte_cnt_d;
    step_q       <= step_d;
    pos_q        <= pos_d;
    res_status_q <= res_status_d;
    res_val_q    <= res_val_d;
    res_key_q    <= res_key_d;
    res_idx_q    <= res_idx_d;
    out_status_q <= out_status_d;
    out_val_q    <= out_val_d;
    out_key_q    <= out_key_d;
    out_idx_q    <= out_idx_d;
  end

  assign in_ready_o   = (state_q == oaht_pkg::ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = out_val_q;
  assign out_key_o    = out_key_q;
  assign out_slot_o   = out_idx_q;

endmodule

// ----- sim/open_addressing_hash_table_test.sv -----
// testbench of the open-addressing hash table: directed and random operations against a predictor
`timescale 1ns / 1ps

module open_addressing_hash_table_test;
  import oaht_pkg::*;

  // mode code with no operation behind it
  localparam logic [1:0]  MODE_UNUSED   = 2'd3;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 20;

  // idle profiles of the two stream sides
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_e;

  typedef struct packed {
    logic [1:0]            status;
    logic [VALUE_BITS-1:0] value_out;
    logic [KEY_W-1:0]      key_out;
    logic [SLOT_W-1:0]     slot_index;
  } result_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;

  idle_e       idle_mode     = IDLE_NONE;
  int unsigned hold_requests = 0;
  int unsigned quiet_cycles  = 0;
  logic [KEY_W-1:0] key_pool[$];

  // raw djb2 over the low nbytes bytes, low byte first
  function automatic logic [TAG_W-1:0] djb2(input logic [KEY_W-1:0] key,
                                            input int unsigned nbytes);
    logic [TAG_W-1:0] h;
    h = HASH_SEED;
    for (int unsigned i = 0; i < nbytes; i++) begin
      h = h * 32'd33 + 32'(key[8*i +: 8]);
    end
    return h;
  endfunction

  // 8-byte key whose raw hash is target: low 3 bytes random, upper 5 solved
  // as digits in base 33, each digit range covering the gap of the next weight
  function automatic logic [KEY_W-1:0] key_hashing_to(input logic [TAG_W-1:0] target);
    logic [KEY_W-1:0] key;
    logic [31:0]      rest;
    logic [31:0]      weight;
    logic [31:0]      digit;
    do begin
      key  = 64'($urandom_range(0, 32'hFF_FFFF));
      rest = target - djb2(key, 3) * 32'd39135393;
    end while (rest > 32'd311860155);
    weight = 32'd1185921;
    for (int b = 3; b < 8; b++) begin
      digit = rest / weight;
      if (digit > 32'd255) begin
        digit = 32'd255;
      end
      key[8*b +: 8] = digit[7:0];
      rest   = rest - digit * weight;
      weight = weight / 32'd33;
    end
    return key;
  endfunction

  // table predictor and queue of expected results
  class table_board;
    logic [TAG_W-1:0]      tag_mem   [SLOTS];
    logic [KEY_W-1:0]      key_mem   [SLOTS];
    logic [VALUE_BITS-1:0] value_mem [SLOTS];
    logic [CNT_W-1:0]      insert_count;
    logic [6:0]            capacity_reg;
    logic [3:0]            key_bytes_reg;
    result_t               pending_q[$];
    int unsigned           errors;

    function new();
      foreach (tag_mem[i]) begin
        tag_mem[i]   = TAG_VACANT;
        key_mem[i]   = '0;
        value_mem[i] = '0;
      end
      insert_count  = '0;
      capacity_reg  = CAP_RESET;
      key_bytes_reg = KB_RESET;
      errors        = 0;
    endfunction

    function void write_register(input logic [CFG_IDX_W-1:0] index,
                                 input logic [CFG_DATA_W-1:0] data);
      if (index == CFG_CAPACITY) begin
        capacity_reg = data;
      end else if (index == CFG_KEY_BYTES) begin
        key_bytes_reg = data[3:0];
      end
    endfunction

    function int unsigned usable_slots();
      if (capacity_reg == 0) return 1;
      if (capacity_reg > SLOTS) return SLOTS;
      return capacity_reg;
    endfunction

    function int unsigned hashed_bytes();
      if (key_bytes_reg == 0) return 1;
      if (key_bytes_reg > 8) return 8;
      return key_bytes_reg;
    endfunction

    function logic [KEY_W-1:0] key_mask();
      if (hashed_bytes() == 8) return '1;
      return (64'd1 << (8 * hashed_bytes())) - 64'd1;
    endfunction

    // slot holding the key, or -1; a vacant slot ends the walk
    function int locate(input logic [KEY_W-1:0] mkey, input logic [TAG_W-1:0] h,
                        input int unsigned cap, input int unsigned span);
      int          slot;
      int unsigned p;
      slot = -1;
      if (insert_count != 0) begin
        for (int unsigned i = 0; i < span; i++) begin
          p = (h + (i + i * i) / 2) & (span - 1);
          if (p < cap) begin
            if (tag_mem[p] == TAG_VACANT) break;
            if (tag_mem[p] == h && (key_mem[p] & key_mask()) == mkey) begin
              slot = p;
              break;
            end
          end
        end
      end
      return slot;
    endfunction

    // accepted input transfer: update the table and queue its result
    function void note_request(input logic [IN_DATA_W-1:0] data);
      logic [1:0]            op;
      logic [KEY_W-1:0]      mkey;
      logic [VALUE_BITS-1:0] val;
      logic [TAG_W-1:0]      h;
      int unsigned           cap;
      int unsigned           span;
      int unsigned           p;
      int                    found;
      result_t               r;
      op   = data[1:0];
      mkey = data[2 +: KEY_W] & key_mask();
      val  = data[66 +: VALUE_BITS];
      h    = djb2(mkey, hashed_bytes());
      if (h < TAG_MIN) begin
        h = TAG_MIN;
      end
      cap  = usable_slots();
      span = 1;
      while (span < cap) begin
        span = span << 1;
      end
      r        = '0;
      r.status = STAT_NOT_FOUND;
      if (op == MODE_LOOKUP || op == MODE_REMOVE) begin
        found = locate(mkey, h, cap, span);
        if (found >= 0) begin
          r.status     = STAT_OK;
          r.value_out  = value_mem[found];
          r.key_out    = key_mem[found];
          r.slot_index = SLOT_W'(found);
          if (op == MODE_REMOVE) begin
            tag_mem[found]   = TAG_DELETED;
            key_mem[found]   = '0;
            value_mem[found] = '0;
          end
        end
      end else if (op == MODE_INSERT) begin
        if (insert_count != '1) begin
          insert_count++;
        end
        r.status = STAT_FULL;
        for (int unsigned i = 0; i < span; i++) begin
          p = (h + (i + i * i) / 2) & (span - 1);
          if (p >= cap) continue;
          if (tag_mem[p] == h && (key_mem[p] & key_mask()) == mkey) begin
            r.status = STAT_DUPLICATE;
            break;
          end
          if (tag_mem[p] >= TAG_MIN) continue;
          tag_mem[p]   = h;
          key_mem[p]   = mkey;
          value_mem[p] = val;
          r.status     = STAT_OK;
          r.slot_index = SLOT_W'(p);
          break;
        end
      end
      pending_q.push_back(r);
    endfunction

    function void compare(input string field, input logic [63:0] expected,
                          input logic [63:0] actual);
      if (expected !== actual) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, expected, actual);
        errors++;
      end
    endfunction

    // accepted result transfer against the oldest expectation
    function void check_result(input logic [OUT_DATA_W-1:0] data);
      result_t r;
      if (pending_q.size() == 0) begin
        $error("result with no operation pending: 0x%0h", data);
        errors++;
      end else begin
        r = pending_q.pop_front();
        compare("status", 64'(r.status), 64'(data[1:0]));
        compare("value_out", 64'(r.value_out), 64'(data[2 +: VALUE_BITS]));
        compare("key_out", 64'(r.key_out), 64'(data[66 +: KEY_W]));
        compare("slot_index", 64'(r.slot_index), 64'(data[130 +: SLOT_W]));
      end
    endfunction
  endclass

  table_board board = new();

  open_addressing_hash_table u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // transfer monitors and watchdog
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      board.note_request(s_axis_tdata_i);
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      board.check_result(m_axis_tdata_o);
    end
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      board.write_register(cfg_index_i, cfg_data_i);
    end
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("open_addressing_hash_table_test: FAIL");
      $finish;
    end
  end

  // result side: random stalls, plus long hold-offs on request
  initial begin
    int unsigned hold_left;
    int unsigned holds_seen;
    int unsigned stall_pct;
    hold_left  = 0;
    holds_seen = 0;
    forever begin
      @(posedge clk_i);
      stall_pct = (idle_mode == IDLE_RECEIVER) ? 66 : (idle_mode == IDLE_BOTH) ? 7 : 0;
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // offer one operation and wait for its transfer
  task automatic send_item(input logic [1:0] mode, input logic [KEY_W-1:0] key,
                           input logic [VALUE_BITS-1:0] value);
    int unsigned idle_pct;
    idle_pct = (idle_mode == IDLE_SENDER) ? 66 : (idle_mode == IDLE_BOTH) ? 7 : 0;
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_DATA_W'({value, key, mode});
    @(posedge clk_i);
    while (!s_axis_tready_o) begin
      @(posedge clk_i);
    end
  endtask

  // stop offering and let every expected result arrive
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    // let the monitor note the last input transfer before the pending queue is polled
    @(posedge clk_i);
    while (board.pending_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // both registers, back to back
  task automatic program_table(input logic [6:0] cap, input logic [3:0] kb);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_CAPACITY;
    cfg_data_i  <= cap;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    cfg_index_i <= CFG_KEY_BYTES;
    cfg_data_i  <= CFG_DATA_W'(kb);
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // random operations, mostly on keys seen before so that hits are common
  task automatic send_random(input int unsigned count, input int hold_at);
    logic [1:0]            mode;
    logic [KEY_W-1:0]      key;
    logic [VALUE_BITS-1:0] value;
    int unsigned           pick;
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) begin
        hold_requests++;
      end
      pick = $urandom_range(0, 99);
      mode = (pick < 36) ? MODE_INSERT : (pick < 66) ? MODE_REMOVE :
             (pick < 95) ? MODE_LOOKUP : MODE_UNUSED;
      if (key_pool.size() != 0 && $urandom_range(0, 99) < 60) begin
        key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        // change bytes that short keys ignore
        if ($urandom_range(0, 9) == 0) begin
          key[63:56] = key[63:56] ^ 8'($urandom_range(1, 255));
        end
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            key = {$urandom, $urandom};
          end
          1: begin
            key = 64'($urandom_range(0, 255));
          end
          default: begin
            key = 64'($urandom) << $urandom_range(0, 32);
          end
        endcase
        if (mode == MODE_INSERT) begin
          key_pool.push_back(key);
          if (key_pool.size() > 96) begin
            void'(key_pool.pop_front());
          end
        end
      end
      pick  = $urandom_range(0, 9);
      value = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom};
      send_item(mode, key, value);
    end
  endtask

  task automatic run_phase(input logic [6:0] cap, input logic [3:0] kb, input idle_e profile,
                           input int unsigned count, input int hold_at);
    wait_drained();
    program_table(cap, kb);
    idle_mode = profile;
    send_random(count, hold_at);
  endtask

  initial begin
    logic [KEY_W-1:0] base_key;
    logic [KEY_W-1:0] zero_hash_key;
    logic [KEY_W-1:0] one_hash_key;
    base_key      = 64'h0123_4567_89AB_CDEF;
    zero_hash_key = key_hashing_to(32'd0);
    one_hash_key  = key_hashing_to(32'd1);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, duplicates, clamped hashes, deleted slots, extremes
    send_item(MODE_LOOKUP, base_key, '0);
    send_item(MODE_REMOVE, base_key, '0);
    send_item(MODE_INSERT, base_key, '1);
    send_item(MODE_INSERT, base_key, '0);
    send_item(MODE_LOOKUP, base_key, '0);
    send_item(MODE_INSERT, zero_hash_key, 64'h5A5A_5A5A_5A5A_5A5A);
    send_item(MODE_INSERT, one_hash_key, 64'hA5A5_A5A5_A5A5_A5A5);
    send_item(MODE_LOOKUP, zero_hash_key, '0);
    send_item(MODE_LOOKUP, one_hash_key, '0);
    send_item(MODE_REMOVE, zero_hash_key, '0);
    send_item(MODE_LOOKUP, one_hash_key, '0);
    send_item(MODE_LOOKUP, zero_hash_key, '0);
    send_item(MODE_INSERT, zero_hash_key, 64'h1357_9BDF_0246_8ACE);
    send_item(MODE_UNUSED, base_key, '1);
    send_item(MODE_LOOKUP, base_key, '0);
    send_item(MODE_INSERT, '0, '0);
    send_item(MODE_INSERT, '1, '1);
    send_item(MODE_LOOKUP, '0, '1);
    send_item(MODE_REMOVE, '1, '0);
    send_item(MODE_REMOVE, '1, '0);
    send_item(MODE_INSERT, base_key ^ 64'hFF00_0000_0000_0000, 64'h8000_0000_0000_0001);
    key_pool.push_back(base_key);
    key_pool.push_back(zero_hash_key);
    key_pool.push_back(one_hash_key);

    // random phases over several table settings, extremes included
    run_phase(7'd1,   4'd0,  IDLE_NONE,     60,  -1);
    run_phase(7'd127, 4'd15, IDLE_SENDER,   200, -1);
    run_phase(7'd2,   4'd1,  IDLE_RECEIVER, 100, -1);
    run_phase(7'd64,  4'd8,  IDLE_BOTH,     250, 50);
    run_phase(7'd33,  4'd2,  IDLE_NONE,     200, -1);
    run_phase(7'd0,   4'd9,  IDLE_SENDER,   60,  -1);
    run_phase(7'd17,  4'd4,  IDLE_RECEIVER, 200, -1);
    run_phase(7'd65,  4'd3,  IDLE_BOTH,     200, -1);
    run_phase(7'd64,  4'd8,  IDLE_NONE,     200, 120);
    run_phase(7'd5,   4'd1,  IDLE_SENDER,   155, -1);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("open_addressing_hash_table_test: PASS");
    end else begin
      $display("open_addressing_hash_table_test: FAIL");
    end
    $finish;
  end

endmodule
